### hdl/svr_pkg.sv
// Shared widths, stage payload types and step functions of the refraction pipeline.
package svr_pkg;

  localparam int DirW      = 16;
  localparam int IdxW      = 15;
  localparam int InDataW   = 128;
  localparam int OutDataW  = 48;
  localparam int EtaW      = 24;
  localparam int DotW      = 29;
  localparam int OmW       = 29;
  localparam int DotSumW   = 34;
  localparam int Eta2W     = 2 * EtaW;
  localparam int ProdW     = 77;
  localparam int RootW     = 31;
  localparam int RadW      = 62;
  localparam int KaW       = 39;
  localparam int KW        = 40;
  localparam int PeW       = 41;
  localparam int PkW       = 56;
  localparam int RW        = 57;
  localparam int MagW      = 56;
  localparam int NrmW      = 30;
  localparam int QuoW      = 15;
  localparam int NumW      = 45;

  localparam logic [DotW-1:0] OneQ28 = 29'h1000_0000;

  localparam int EtaSteps    = 3;
  localparam int EtaStages   = EtaW / EtaSteps;
  localparam int SqrtDigits  = RootW;
  localparam int SqrtSteps   = 2;
  localparam int SqrtStages  = (SqrtDigits + SqrtSteps - 1) / SqrtSteps;
  localparam int QSteps      = 3;
  localparam int QStages     = QuoW / QSteps;
  localparam int NumStages   = 4 + EtaStages + 3 + SqrtStages + 1 + 3 + 2 + 2 + SqrtStages
                               + 1 + QStages + 1;

  typedef logic signed [DirW-1:0] comp_t;

  typedef struct packed {
    comp_t [2:0] d;
    comp_t [2:0] n;
  } ray_t;

  typedef struct packed {
    logic [IdxW-1:0] rem;
    logic [EtaW-1:0] stream;
    logic [EtaW-1:0] quo;
  } eta_acc_t;

  typedef struct packed {
    logic [RadW-1:0]    x;
    logic [RootW+2:0]   rem;
    logic [RootW-1:0]   root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [QuoW-1:0]  stream;
    logic [QuoW-1:0]  quo;
  } q_acc_t;

  typedef struct packed {
    ray_t            ray;
    logic [DotW-1:0] dot;
    logic [OmW-1:0]  om;
    logic [IdxW-1:0] den;
    logic            sat;
    eta_acc_t        acc;
  } edv_t;

  typedef struct packed {
    ray_t            ray;
    logic [EtaW-1:0] eta;
    logic [KaW-1:0]  ka;
    logic            tir;
    sqrt_acc_t       acc;
  } sq1_t;

  typedef struct packed {
    logic [2:0][NrmW-1:0] an;
    logic [2:0]           neg;
    logic                 tir;
    logic                 zero;
    sqrt_acc_t            acc;
  } sq2_t;

  typedef struct packed {
    logic [RootW-1:0] den;
    logic [2:0]       neg;
    logic             tir;
    logic             zero;
    q_acc_t [2:0]     acc;
  } qdv_t;

  // one restoring division step of the index ratio
  function automatic eta_acc_t eta_step(eta_acc_t a, logic [IdxW-1:0] den);
    logic [IdxW:0] r2;
    eta_acc_t      o;
    r2       = {a.rem, a.stream[EtaW-1]};
    o.stream = {a.stream[EtaW-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = IdxW'(r2 - {1'b0, den});
      o.quo = {a.quo[EtaW-2:0], 1'b1};
    end else begin
      o.rem = r2[IdxW-1:0];
      o.quo = {a.quo[EtaW-2:0], 1'b0};
    end
    return o;
  endfunction

  // one digit of the integer square root, two radicand bits at a time
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a);
    logic [RootW+4:0] r2;
    logic [RootW+4:0] t;
    sqrt_acc_t        o;
    r2  = {a.rem, a.x[RadW-1 -: 2]};
    t   = {3'b000, a.root, 2'b01};
    o.x = {a.x[RadW-3:0], 2'b00};
    if (r2 >= t) begin
      o.rem  = (RootW+3)'(r2 - t);
      o.root = {a.root[RootW-2:0], 1'b1};
    end else begin
      o.rem  = r2[RootW+2:0];
      o.root = {a.root[RootW-2:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring division step of a normalized component by the length
  function automatic q_acc_t q_step(q_acc_t a, logic [RootW-1:0] den);
    logic [RootW:0] r2;
    q_acc_t         o;
    r2       = {a.rem, a.stream[QuoW-1]};
    o.stream = {a.stream[QuoW-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = RootW'(r2 - {1'b0, den});
      o.quo = {a.quo[QuoW-2:0], 1'b1};
    end else begin
      o.rem = r2[RootW-1:0];
      o.quo = {a.quo[QuoW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### hdl/snell_vector_refraction.sv
// Pipelined vector refraction: ray direction, normal and indices in, refracted direction out.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------------
//  s_axis   | in  | tdata: dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to
//  m_axis   | out | tdata: out_x, out_y, out_z   tuser: total_reflection
//
//  One request per cycle unless the output stalls.
//  The depth comes from the 24-step ratio divider, two 31-digit square root pipelines
//  and the 15-step output divider, with 3, 2 and 3 steps per stage.
//  rst_ni clears only the valid bits of the stages.
//  When the result register is full and not taken, every stage holds and s_axis_tready
//  drops in the same cycle.
module snell_vector_refraction import svr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to, 2 unused bits
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_x, out_y, out_z
  output logic [OutDataW-1:0] m_axis_tdata,
  // total_reflection
  output logic                m_axis_tuser
);

  logic                 adv;
  logic [NumStages-1:0] vld_q;

  assign adv           = ~vld_q[NumStages-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // input register
  ray_t            s0_ray_q;
  logic [IdxW-1:0] s0_n1_q, s0_n2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_ray_q.d <= s_axis_tdata[3*DirW-1:0];
      s0_ray_q.n <= s_axis_tdata[6*DirW-1:3*DirW];
      s0_n1_q    <= s_axis_tdata[6*DirW +: IdxW];
      s0_n2_q    <= s_axis_tdata[6*DirW+IdxW +: IdxW];
    end
  end

  // dot product terms
  ray_t                     s1_ray_q;
  logic [IdxW-1:0]          s1_n1_q, s1_n2_q;
  logic signed [2*DirW-1:0] s1_prod_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ray_q <= s0_ray_q;
      s1_n1_q  <= s0_n1_q;
      s1_n2_q  <= s0_n2_q;
      for (int i = 0; i < 3; i++) begin
        s1_prod_q[i] <= $signed(s0_ray_q.d[i]) * $signed(s0_ray_q.n[i]);
      end
    end
  end

  // clamped cosine
  logic signed [DotSumW-1:0] s2_sum;
  logic [DotW-1:0]           s2_dot_d, s2_dot_q;
  ray_t                      s2_ray_q;
  logic [IdxW-1:0]           s2_n1_q, s2_n2_q;

  always_comb begin
    s2_sum = s1_prod_q[0] + s1_prod_q[1] + s1_prod_q[2];
    if (s2_sum < 0) begin
      s2_dot_d = '0;
    end else if (s2_sum > $signed({5'b0, OneQ28})) begin
      s2_dot_d = OneQ28;
    end else begin
      s2_dot_d = s2_sum[DotW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dot_q <= s2_dot_d;
      s2_ray_q <= s1_ray_q;
      s2_n1_q  <= s1_n1_q;
      s2_n2_q  <= s1_n2_q;
    end
  end

  // 1 - cos^2 and divider setup
  logic [2*DotW-1:0] s3_dsq;
  logic [56:0]       s3_diff;
  edv_t              edv_q [EtaStages+1];
  edv_t              s3_d;

  always_comb begin
    s3_dsq         = s2_dot_q * s2_dot_q;
    s3_diff        = {1'b1, 56'b0} - s3_dsq[56:0];
    s3_d.ray       = s2_ray_q;
    s3_d.dot       = s2_dot_q;
    s3_d.om        = s3_diff[56:28];
    s3_d.den       = s2_n2_q;
    // saturate when the ratio needs more than 24 bits, zero divisor included
    s3_d.sat       = ({8'b0, s2_n1_q} >= {s2_n2_q, 8'b0});
    s3_d.acc.rem   = {8'b0, s2_n1_q[IdxW-1:8]};
    s3_d.acc.stream = {s2_n1_q[7:0], 16'b0};
    s3_d.acc.quo   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      edv_q[0] <= s3_d;
    end
  end

  for (genvar g = 1; g <= EtaStages; g++) begin : g_eta
    edv_t edv_d;
    always_comb begin
      edv_d = edv_q[g-1];
      for (int j = 0; j < EtaSteps; j++) begin
        edv_d.acc = eta_step(edv_d.acc, edv_d.den);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        edv_q[g] <= edv_d;
      end
    end
  end

  // eta and eta squared
  logic [EtaW-1:0]  e1_eta_d, e1_eta_q;
  logic [Eta2W-1:0] e1_eta2_q;
  ray_t             e1_ray_q;
  logic [DotW-1:0]  e1_dot_q;
  logic [OmW-1:0]   e1_om_q;

  assign e1_eta_d = edv_q[EtaStages].sat ? '1 : edv_q[EtaStages].acc.quo;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_eta_q  <= e1_eta_d;
      e1_eta2_q <= e1_eta_d * e1_eta_d;
      e1_ray_q  <= edv_q[EtaStages].ray;
      e1_dot_q  <= edv_q[EtaStages].dot;
      e1_om_q   <= edv_q[EtaStages].om;
    end
  end

  // split product eta^2 * (1 - cos^2), and eta * cos
  logic [EtaW+OmW-1:0] e2_phi_q, e2_plo_q, e2_ed_q;
  ray_t                e2_ray_q;
  logic [EtaW-1:0]     e2_eta_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_phi_q <= e1_eta2_q[Eta2W-1:EtaW] * e1_om_q;
      e2_plo_q <= e1_eta2_q[EtaW-1:0] * e1_om_q;
      e2_ed_q  <= e1_eta_q * e1_dot_q;
      e2_ray_q <= e1_ray_q;
      e2_eta_q <= e1_eta_q;
    end
  end

  // total reflection test and radicand of cos_t
  logic [ProdW-1:0] e3_prod;
  logic [60:0]      e3_rad;
  sq1_t             sq1_q [SqrtStages+1];
  sq1_t             e3_d;

  always_comb begin
    e3_prod         = {e2_phi_q, 24'b0} + {24'b0, e2_plo_q};
    e3_rad          = {1'b1, 60'b0} - {1'b0, e3_prod[59:0]};
    e3_d.ray        = e2_ray_q;
    e3_d.eta        = e2_eta_q;
    e3_d.ka         = e2_ed_q[KaW+13:14];
    e3_d.tir        = |e3_prod[ProdW-1:60];
    e3_d.acc.x      = {1'b0, e3_rad};
    e3_d.acc.rem    = '0;
    e3_d.acc.root   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq1_q[0] <= e3_d;
    end
  end

  for (genvar g = 1; g <= SqrtStages; g++) begin : g_sq1
    sq1_t sq1_d;
    always_comb begin
      sq1_d = sq1_q[g-1];
      for (int j = 0; j < SqrtSteps; j++) begin
        if ((g-1)*SqrtSteps + j < SqrtDigits) begin
          sq1_d.acc = sqrt_step(sq1_d.acc);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq1_q[g] <= sq1_d;
      end
    end
  end

  // k = eta*cos_i - cos_t
  logic signed [KW-1:0] k_q;
  ray_t                 k_ray_q;
  logic [EtaW-1:0]      k_eta_q;
  logic                 k_tir_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_q     <= $signed({1'b0, sq1_q[SqrtStages].ka})
               - $signed({9'b0, sq1_q[SqrtStages].acc.root});
      k_ray_q <= sq1_q[SqrtStages].ray;
      k_eta_q <= sq1_q[SqrtStages].eta;
      k_tir_q <= sq1_q[SqrtStages].tir;
    end
  end

  // refracted vector terms
  logic signed [PeW-1:0] r1_pe_q [3];
  logic signed [PkW-1:0] r1_pk_q [3];
  logic                  r1_tir_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r1_pe_q[i] <= $signed({1'b0, k_eta_q}) * $signed(k_ray_q.d[i]);
        r1_pk_q[i] <= k_q * $signed(k_ray_q.n[i]);
      end
      r1_tir_q <= k_tir_q;
    end
  end

  // magnitudes and signs
  logic signed [RW-1:0] r2_pe [3];
  logic signed [RW-1:0] r2_pk [3];
  logic signed [RW-1:0] r2_r [3];
  logic [MagW-1:0]      r2_a_d [3];
  logic [2:0]           r2_neg_d;
  logic [MagW-1:0]      r2_a_q [3];
  logic [2:0]           r2_neg_q;
  logic                 r2_tir_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2_pe[i]    = r1_pe_q[i];
      r2_pk[i]    = r1_pk_q[i];
      r2_r[i]     = (r2_pe[i] <<< 14) - r2_pk[i];
      r2_neg_d[i] = r2_r[i][RW-1];
      r2_a_d[i]   = r2_neg_d[i] ? MagW'(-r2_r[i]) : MagW'(r2_r[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_a_q   <= r2_a_d;
      r2_neg_q <= r2_neg_d;
      r2_tir_q <= r1_tir_q;
    end
  end

  // largest magnitude
  logic [MagW-1:0] r3_m_d, r3_m_q;
  logic [MagW-1:0] r3_a_q [3];
  logic [2:0]      r3_neg_q;
  logic            r3_tir_q;

  always_comb begin
    r3_m_d = r2_a_q[0];
    if (r2_a_q[1] > r3_m_d) r3_m_d = r2_a_q[1];
    if (r2_a_q[2] > r3_m_d) r3_m_d = r2_a_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r3_m_q   <= r3_m_d;
      r3_a_q   <= r2_a_q;
      r3_neg_q <= r2_neg_q;
      r3_tir_q <= r2_tir_q;
    end
  end

  // coarse normalize: shift out leading zero bytes
  logic [2:0]      n1_hi;
  logic [5:0]      n1_sh;
  logic [MagW-1:0] n1_m_q;
  logic [MagW-1:0] n1_a_q [3];
  logic [2:0]      n1_neg_q;
  logic            n1_tir_q, n1_zero_q;

  always_comb begin
    n1_hi = '0;
    for (int b = 0; b < MagW/8; b++) begin
      if (r3_m_q[8*b +: 8] != '0) n1_hi = 3'(b);
    end
    n1_sh = 6'((MagW/8 - 1 - int'(n1_hi)) * 8);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_m_q <= r3_m_q << n1_sh;
      for (int i = 0; i < 3; i++) begin
        n1_a_q[i] <= r3_a_q[i] << n1_sh;
      end
      n1_neg_q  <= r3_neg_q;
      n1_tir_q  <= r3_tir_q;
      n1_zero_q <= (r3_m_q == '0);
    end
  end

  // fine normalize: leading one of the largest to the top, keep 30 bits
  logic [2:0]      n2_f;
  logic [MagW-1:0] n2_t [3];
  logic [NrmW-1:0] n2_an_q [3];
  logic [2:0]      n2_neg_q;
  logic            n2_tir_q, n2_zero_q;

  always_comb begin
    n2_f = '0;
    for (int b = 0; b < 8; b++) begin
      if (n1_m_q[MagW-8+b]) n2_f = 3'(7 - b);
    end
    for (int i = 0; i < 3; i++) begin
      n2_t[i] = n1_a_q[i] << n2_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n2_an_q[i] <= n2_t[i][MagW-1 -: NrmW];
      end
      n2_neg_q  <= n1_neg_q;
      n2_tir_q  <= n1_tir_q;
      n2_zero_q <= n1_zero_q;
    end
  end

  // squares
  logic [2*NrmW-1:0] q1_sq_q [3];
  logic [NrmW-1:0]   q1_an_q [3];
  logic [2:0]        q1_neg_q;
  logic              q1_tir_q, q1_zero_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q1_sq_q[i] <= n2_an_q[i] * n2_an_q[i];
      end
      q1_an_q   <= n2_an_q;
      q1_neg_q  <= n2_neg_q;
      q1_tir_q  <= n2_tir_q;
      q1_zero_q <= n2_zero_q;
    end
  end

  // sum of squares into the length root
  sq2_t sq2_q [SqrtStages+1];
  sq2_t q2_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q2_d.an[i] = q1_an_q[i];
    end
    q2_d.neg      = q1_neg_q;
    q2_d.tir      = q1_tir_q;
    q2_d.zero     = q1_zero_q;
    q2_d.acc.x    = RadW'(q1_sq_q[0]) + RadW'(q1_sq_q[1]) + RadW'(q1_sq_q[2]);
    q2_d.acc.rem  = '0;
    q2_d.acc.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq2_q[0] <= q2_d;
    end
  end

  for (genvar g = 1; g <= SqrtStages; g++) begin : g_sq2
    sq2_t sq2_d;
    always_comb begin
      sq2_d = sq2_q[g-1];
      for (int j = 0; j < SqrtSteps; j++) begin
        if ((g-1)*SqrtSteps + j < SqrtDigits) begin
          sq2_d.acc = sqrt_step(sq2_d.acc);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq2_q[g] <= sq2_d;
      end
    end
  end

  // rounded division setup: (a * 2^14 + len/2) / len
  logic [RootW-1:0] d0_len;
  logic [NumW-1:0]  d0_num [3];
  qdv_t             qdv_q [QStages+1];
  qdv_t             d0_d;

  always_comb begin
    d0_len    = sq2_q[SqrtStages].acc.root;
    d0_d.den  = d0_len;
    d0_d.neg  = sq2_q[SqrtStages].neg;
    d0_d.tir  = sq2_q[SqrtStages].tir;
    d0_d.zero = sq2_q[SqrtStages].zero;
    for (int i = 0; i < 3; i++) begin
      d0_num[i] = {1'b0, sq2_q[SqrtStages].an[i], 14'b0} + {15'b0, d0_len[RootW-1:1]};
      d0_d.acc[i].rem    = {1'b0, d0_num[i][NumW-1:QuoW]};
      d0_d.acc[i].stream = d0_num[i][QuoW-1:0];
      d0_d.acc[i].quo    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qdv_q[0] <= d0_d;
    end
  end

  for (genvar g = 1; g <= QStages; g++) begin : g_qdv
    qdv_t qdv_d;
    always_comb begin
      qdv_d = qdv_q[g-1];
      for (int j = 0; j < QSteps; j++) begin
        for (int i = 0; i < 3; i++) begin
          qdv_d.acc[i] = q_step(qdv_d.acc[i], qdv_d.den);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        qdv_q[g] <= qdv_d;
      end
    end
  end

  // result register: reapply signs, drop to zero on reflection or vanishing vector
  logic [DirW-1:0]     out_qe [3];
  logic [DirW-1:0]     out_v [3];
  logic [OutDataW-1:0] m_data_q;
  logic                m_user_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_qe[i] = {1'b0, qdv_q[QStages].acc[i].quo};
      if (qdv_q[QStages].tir || qdv_q[QStages].zero) begin
        out_v[i] = '0;
      end else if (qdv_q[QStages].neg[i]) begin
        out_v[i] = -out_qe[i];
      end else begin
        out_v[i] = out_qe[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {out_v[2], out_v[1], out_v[0]};
      m_user_q <= qdv_q[QStages].tir;
    end
  end

  assign m_axis_tdata = m_data_q;
  assign m_axis_tuser = m_user_q;

endmodule

### hdl/svr_checker.sv
// Port-level checks of the refraction pipeline and their binding to the top level.
module svr_checker import svr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  function automatic logic in_unit(logic [DirW-1:0] v);
    return ($signed(v) <= 16'sd16384) && ($signed(v) >= -16'sd16384);
  endfunction

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an empty result register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero direction on total reflection");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> in_unit(m_axis_tdata[15:0]) && in_unit(m_axis_tdata[31:16])
                      && in_unit(m_axis_tdata[47:32]))
    else $error("output component beyond unit range");

endmodule

bind snell_vector_refraction svr_checker u_svr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
